// File: src/deq_pkg.sv
package deq_pkg;

  // Number of element cells in the chain and the width of one stored element.
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ELEM_WIDTH = 32;

  // Elements arrive and leave on 32-bit ports, so no more than 32 bits are ever kept.
  localparam int unsigned StoreW = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
  localparam int unsigned CountW = $clog2(DEPTH + 1);

  typedef logic [StoreW-1:0] elem_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_CLEAR      = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Operation broadcast to every cell; at most one member is set in a cycle.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: src/deq_cell.sv
module deq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  deq_pkg::cell_ctrl_t ctrl_i,
  input  deq_pkg::elem_t     push_data_i,
  input  deq_pkg::elem_t     prev_data_i,
  input  logic               prev_valid_i,
  input  deq_pkg::elem_t     next_data_i,
  input  logic               next_valid_i,
  output deq_pkg::elem_t     data_o,
  output logic               valid_o,
  output logic               is_back_o
);
  import deq_pkg::*;

  elem_t data_q, data_d;
  logic  valid_q, valid_d;

  // A cell holds one element. Pushing at the front moves every element one
  // cell towards the back; popping at the front moves them one cell forwards.
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    priority if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.push_front) begin
      data_d  = prev_data_i;
      valid_d = prev_valid_i;
    end else if (ctrl_i.pop_front) begin
      data_d  = next_data_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.push_back) begin
      if (!valid_q && prev_valid_i) begin
        data_d  = push_data_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.pop_back) begin
      if (valid_q && !next_valid_i) begin
        valid_d = 1'b0;
      end
    end else begin
      // No operation in this cycle: the cell keeps its element.
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign valid_o   = valid_q;
  assign is_back_o = valid_q && !next_valid_i;

endmodule

// File: src/double_ended_queue.sv
// Bounded double-ended queue built as a chain of element cells, the front element
// always in the first cell. A request is accepted at any rising edge at which start
// is high; busy is never raised, so one request may follow another in every cycle.
// Each request yields exactly one result, shown for one cycle with done_o high in
// the cycle after acceptance. The receiver cannot stall, so the result must be
// captured in that cycle. The result gives the status (ok, empty on a pop or peek of
// an empty queue, full on a push into a full queue), the element popped or peeked
// (zero otherwise), and the element count and empty flag after the request.
// Clear empties the queue at once, and unused mode codes change nothing and
// report ok.
module double_ended_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [31:0] push_value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] pop_value_o,
  output logic [4:0]  count_o,
  output logic        is_empty_o
);
  import deq_pkg::*;

  // The queue keeps the front element in cell 0. Every cell sees the same
  // operation and its two neighbours, so a push or pop at the front is one shift
  // of the whole chain. A push at the back fills the first empty cell. A pop at
  // the back empties the last full cell.
  elem_t      cell_data  [DEPTH];
  logic       cell_valid [DEPTH];
  logic       cell_back  [DEPTH];
  elem_t      prev_data  [DEPTH];
  logic       prev_valid [DEPTH];
  elem_t      next_data  [DEPTH];
  logic       next_valid [DEPTH];

  cell_ctrl_t ctrl;
  elem_t      push_data;
  elem_t      back_data;
  count_t     count_q, count_d;
  logic       is_full, is_empty;
  logic       transfer;

  logic       done_q;
  status_e    status_q, status_d;
  elem_t      result_q, result_d;

  assign busy      = 1'b0;
  assign transfer  = start && !busy;
  assign push_data = elem_t'(push_value_i);
  assign is_full   = (count_q == count_t'(DEPTH));
  assign is_empty  = (count_q == '0);

  // The back element is the only full cell whose successor is empty.
  // Its data is selected by a one-hot OR over the chain.
  always_comb begin
    back_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      back_data = back_data | (cell_data[k] & {StoreW{cell_back[k]}});
    end
  end

  // Decode the request into one cell operation, its status and the count
  // that follows it. Refused requests leave the chain untouched.
  always_comb begin
    ctrl     = '0;
    status_d = STATUS_OK;
    result_d = '0;
    count_d  = count_q;
    if (transfer) begin
      unique case (mode_i)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (is_full) begin
            status_d = STATUS_FULL;
          end else begin
            ctrl.push_front = (mode_i == MODE_PUSH_FRONT);
            ctrl.push_back  = (mode_i == MODE_PUSH_BACK);
            count_d         = count_q + count_t'(1);
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT: begin
          if (is_empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            ctrl.pop_front = (mode_i == MODE_POP_FRONT);
            ctrl.pop_back  = (mode_i == MODE_POP_BACK);
            result_d       = (mode_i == MODE_POP_BACK) ? back_data : cell_data[0];
            if (mode_i != MODE_PEEK_FRONT) begin
              count_d = count_q - count_t'(1);
            end
          end
        end
        MODE_CLEAR: begin
          ctrl.clear = 1'b1;
          count_d    = '0;
        end
        default: begin
          // Unused codes leave the queue as it is.
        end
      endcase
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign prev_data[k]  = push_data;
      assign prev_valid[k] = 1'b1;
    end else begin : g_inner_prev
      assign prev_data[k]  = cell_data[k-1];
      assign prev_valid[k] = cell_valid[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_data[k]  = '0;
      assign next_valid[k] = 1'b0;
    end else begin : g_inner_next
      assign next_data[k]  = cell_data[k+1];
      assign next_valid[k] = cell_valid[k+1];
    end

    deq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .push_data_i  (push_data),
      .prev_data_i  (prev_data[k]),
      .prev_valid_i (prev_valid[k]),
      .next_data_i  (next_data[k]),
      .next_valid_i (next_valid[k]),
      .data_o       (cell_data[k]),
      .valid_o      (cell_valid[k]),
      .is_back_o    (cell_back[k])
    );
  end

  // The result register holds each outcome for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= transfer;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    result_q <= result_d;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign pop_value_o = 32'(result_q);
  assign count_o     = 5'(count_q);
  assign is_empty_o  = (count_q == '0);

endmodule
